// ===== sv/bmdw_pkg.sv =====
`timescale 1ns / 1ps
// Shared types, constants and helper functions for the binary morphology disk window.
// No dependencies; every other file of the block imports this package.
package bmdw_pkg;

  localparam int RADIUS_DEF    = 2;
  localparam int MAX_WIDTH_DEF = 1024;
  localparam int MAX_HEIGHT    = 4096;

  localparam int OP_W    = 1;
  localparam int IMG_W_W = 11;
  localparam int IMG_H_W = 13;

  localparam int ADDR_W  = 4;
  localparam int DATA_W  = 32;
  localparam int TDATA_W = 8;

  localparam logic [1:0] REG_OPERATION    = 2'd0;
  localparam logic [1:0] REG_IMAGE_WIDTH  = 2'd1;
  localparam logic [1:0] REG_IMAGE_HEIGHT = 2'd2;

  localparam logic KIND_PIXEL = 1'b0;
  localparam logic KIND_DRAIN = 1'b1;

  localparam logic [OP_W-1:0] OP_ERODE  = 1'b0;
  localparam logic [OP_W-1:0] OP_DILATE = 1'b1;

  localparam logic [OP_W-1:0]    OPERATION_RST    = OP_ERODE;
  localparam logic [IMG_W_W-1:0] IMAGE_WIDTH_RST  = 11'd64;
  localparam logic [IMG_H_W-1:0] IMAGE_HEIGHT_RST = 13'd64;

  typedef struct packed {
    logic rd_en;
    logic wr_en;
    logic shift_en;
  } cell_ctl_t;

  typedef struct packed {
    logic [OP_W-1:0]    operation;
    logic [IMG_W_W-1:0] image_width;
    logic [IMG_H_W-1:0] image_height;
    logic               restart;
  } cfg_t;

  function automatic logic in_disk(input int dy, input int dx, input int rad);
    return (dy * dy + dx * dx) <= (rad * rad);
  endfunction

endpackage

// ===== sv/bmdw_regs.sv =====
`timescale 1ns / 1ps
// Configuration register file behind the APB-style port.
// Depends on bmdw_pkg for register indexes, widths and reset values.
module bmdw_regs import bmdw_pkg::*; (
  input  logic              clk,
  input  logic              rst,
  input  logic              psel,
  input  logic              penable,
  input  logic              pwrite,
  input  logic [ADDR_W-1:0] paddr,
  input  logic [DATA_W-1:0] pwdata,
  output logic [DATA_W-1:0] prdata,
  output logic              pready,
  output cfg_t              cfg
);

  logic [ADDR_W-3:0]  idx;
  logic               wr;
  logic [OP_W-1:0]    operation;
  logic [IMG_W_W-1:0] image_width;
  logic [IMG_H_W-1:0] image_height;

  assign idx    = paddr[ADDR_W-1:2];
  assign wr     = psel && penable && pwrite && pready;
  assign pready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      operation    <= OPERATION_RST;
      image_width  <= IMAGE_WIDTH_RST;
      image_height <= IMAGE_HEIGHT_RST;
    end else if (wr) begin
      case (idx)
        REG_OPERATION:    operation    <= pwdata[OP_W-1:0];
        REG_IMAGE_WIDTH:  image_width  <= pwdata[IMG_W_W-1:0];
        REG_IMAGE_HEIGHT: image_height <= pwdata[IMG_H_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (idx)
      REG_OPERATION:    prdata = DATA_W'(operation);
      REG_IMAGE_WIDTH:  prdata = DATA_W'(image_width);
      REG_IMAGE_HEIGHT: prdata = DATA_W'(image_height);
      default:          prdata = '0;
    endcase
  end

  assign cfg.operation    = operation;
  assign cfg.image_width  = image_width;
  assign cfg.image_height = image_height;
  assign cfg.restart      = wr && (idx inside {REG_OPERATION, REG_IMAGE_WIDTH, REG_IMAGE_HEIGHT});

endmodule

// ===== sv/bmdw_cell.sv =====
`timescale 1ns / 1ps
// One row cell of the window chain: a line memory (when HAS_LINE is set) that delays its
// input by one image row, and one row of the kernel window. Depends on bmdw_pkg.
module bmdw_cell import bmdw_pkg::*; #(
  parameter int RADIUS    = RADIUS_DEF,
  parameter int MAX_WIDTH = MAX_WIDTH_DEF,
  parameter int ROW       = 0,
  parameter bit HAS_LINE  = 1'b1
) (
  input  logic                         clk,
  input  cell_ctl_t                    ctl,
  input  logic [$clog2(MAX_WIDTH)-1:0] rd_addr,
  input  logic [$clog2(MAX_WIDTH)-1:0] wr_addr,
  input  logic                         din,
  output logic                         line_out,
  output logic                         row_all,
  output logic                         row_any
);

  localparam int TAPS = 2 * RADIUS + 1;

  logic [TAPS-1:0] win;
  logic [TAPS-1:0] kmask;

  always_ff @(posedge clk) begin
    if (ctl.shift_en) begin
      win <= {win[TAPS-2:0], din};
    end
  end

  always_comb begin
    for (int j = 0; j < TAPS; j++) begin
      kmask[j] = in_disk(ROW - RADIUS, j - RADIUS, RADIUS);
    end
  end

  assign row_all = &(win | ~kmask);
  assign row_any = |(win & kmask);

  generate
    if (HAS_LINE) begin : g_line
      logic line_mem [MAX_WIDTH];

      always_ff @(posedge clk) begin
        if (ctl.rd_en) begin
          line_out <= line_mem[rd_addr];
        end
      end

      always_ff @(posedge clk) begin
        if (ctl.wr_en) begin
          line_mem[wr_addr] <= din;
        end
      end
    end else begin : g_no_line
      assign line_out = 1'b0;
    end
  endgenerate

endmodule

// ===== sv/bmdw_ctrl.sv =====
`timescale 1ns / 1ps
// Raster position counters, border and frame-end logic, and the elastic
// pipeline with its output register. Depends on bmdw_pkg.
module bmdw_ctrl import bmdw_pkg::*; #(
  parameter int RADIUS    = RADIUS_DEF,
  parameter int MAX_WIDTH = MAX_WIDTH_DEF
) (
  input  logic                         clk,
  input  logic                         rst,
  input  cfg_t                         cfg,
  input  logic                         s_tvalid,
  output logic                         s_tready,
  input  logic                         s_kind,
  input  logic                         s_bit,
  output logic                         m_tvalid,
  input  logic                         m_tready,
  output logic                         m_result,
  output logic                         m_last,
  input  logic                         hit,
  output cell_ctl_t                    cell_ctl,
  output logic [$clog2(MAX_WIDTH)-1:0] rd_addr,
  output logic [$clog2(MAX_WIDTH)-1:0] wr_addr,
  output logic                         din0
);

  localparam int COL_W = $clog2(MAX_WIDTH);
  localparam int LAG_W = $clog2(RADIUS * MAX_WIDTH + RADIUS + 1);

  logic [IMG_W_W-1:0] w_eff;
  logic [IMG_H_W-1:0] h_eff;
  logic [LAG_W-1:0]   lag;

  logic [IMG_H_W-1:0] in_row;
  logic [COL_W-1:0]   in_col;
  logic [LAG_W-1:0]   lead;
  logic [IMG_H_W-1:0] out_row;
  logic [COL_W-1:0]   out_col;

  logic accept, drain_phase, is_pix, emit;
  logic in_col_last, out_col_last, out_row_last, last_out, border;

  logic             s1_valid, s1_pix, s1_bit, s1_emit, s1_border, s1_last;
  logic [COL_W-1:0] s1_col;
  logic             s2_valid, s2_border, s2_last;
  logic             out_free, s2_free, s1_free, s1_move, s2_move;

  always_comb begin
    if (cfg.image_width == '0) begin
      w_eff = IMG_W_W'(1);
    end else if (32'(cfg.image_width) > 32'(MAX_WIDTH)) begin
      w_eff = IMG_W_W'(MAX_WIDTH);
    end else begin
      w_eff = cfg.image_width;
    end
    if (cfg.image_height == '0) begin
      h_eff = IMG_H_W'(1);
    end else if (32'(cfg.image_height) > 32'(MAX_HEIGHT)) begin
      h_eff = IMG_H_W'(MAX_HEIGHT);
    end else begin
      h_eff = cfg.image_height;
    end
  end

  assign lag = LAG_W'(32'(RADIUS) * 32'(w_eff) + 32'(RADIUS));

  assign drain_phase  = (in_row >= h_eff);
  assign is_pix       = !drain_phase && (s_kind == KIND_PIXEL);
  assign emit         = drain_phase || (is_pix && (lead == lag));
  assign accept       = s_tvalid && s_tready;

  assign in_col_last  = (32'(in_col) + 32'd1 >= 32'(w_eff));
  assign out_col_last = (32'(out_col) + 32'd1 >= 32'(w_eff));
  assign out_row_last = (32'(out_row) + 32'd1 >= 32'(h_eff));
  assign last_out     = out_row_last && out_col_last;
  assign border       = (32'(out_row) < 32'(RADIUS))
                     || (32'(out_row) + 32'(RADIUS) >= 32'(h_eff))
                     || (32'(out_col) < 32'(RADIUS))
                     || (32'(out_col) + 32'(RADIUS) >= 32'(w_eff));

  always_ff @(posedge clk) begin
    if (rst || cfg.restart) begin
      in_row  <= '0;
      in_col  <= '0;
      lead    <= '0;
      out_row <= '0;
      out_col <= '0;
    end else if (accept) begin
      if (emit && last_out) begin
        in_row  <= '0;
        in_col  <= '0;
        lead    <= '0;
        out_row <= '0;
        out_col <= '0;
      end else begin
        if (is_pix) begin
          in_col <= in_col_last ? '0 : in_col + 1'b1;
          if (in_col_last) begin
            in_row <= in_row + 1'b1;
          end
          if (lead != lag) begin
            lead <= lead + 1'b1;
          end
        end
        if (emit) begin
          out_col <= out_col_last ? '0 : out_col + 1'b1;
          if (out_col_last) begin
            out_row <= out_row + 1'b1;
          end
        end
      end
    end
  end

  assign out_free = !m_tvalid || m_tready;
  assign s2_free  = !s2_valid || out_free;
  assign s1_free  = !s1_valid || s2_free;
  assign s1_move  = s1_valid && s2_free;
  assign s2_move  = s2_valid && out_free;
  assign s_tready = s1_free;

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
      s2_valid <= 1'b0;
      m_tvalid <= 1'b0;
    end else begin
      if (s1_free) begin
        s1_valid <= accept && (is_pix || emit);
      end
      if (s2_free) begin
        s2_valid <= s1_move && s1_emit;
      end
      if (out_free) begin
        m_tvalid <= s2_move;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      s1_pix    <= is_pix;
      s1_bit    <= s_bit;
      s1_col    <= in_col;
      s1_emit   <= emit;
      s1_border <= border;
      s1_last   <= last_out;
    end
    if (s1_move) begin
      s2_border <= s1_border;
      s2_last   <= s1_last;
    end
    if (s2_move) begin
      m_result <= !s2_border && hit;
      m_last   <= s2_last;
    end
  end

  assign cell_ctl.rd_en    = accept && is_pix;
  assign cell_ctl.wr_en    = s1_move && s1_pix;
  assign cell_ctl.shift_en = s1_move && s1_pix;
  assign rd_addr           = in_col;
  assign wr_addr           = s1_col;
  assign din0              = s1_bit;

endmodule

// ===== sv/binary_morphology_disk_window.sv =====
`timescale 1ns / 1ps
// Streaming binary erosion or dilation of a raster-order mask with a disk kernel of
// radius RADIUS. The block takes one stream transfer per clock and gives one result per
// clock when both sides keep pace; the result of a transfer passes through the s1 and s2
// stages and then the output register, and the chain of 2*RADIUS+1 row cells all shift
// once per pixel. Result pixel q leaves with input pixel q + RADIUS*width + RADIUS, so
// after the last frame pixel that many drain ticks (or further pixels) flush the rest.
// Pixels within RADIUS of any border read as 0. Each row cell but the last owns a line
// memory of MAX_WIDTH bits; its stale contents reach only border results, so it needs no
// clearing after reset. Writing any of the three registers restarts the frame.
module binary_morphology_disk_window import bmdw_pkg::*; #(
  parameter int RADIUS    = RADIUS_DEF,
  parameter int MAX_WIDTH = MAX_WIDTH_DEF
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               s_tvalid,
  output logic               s_tready,
  input  logic [TDATA_W-1:0] s_tdata,   // [0] mask_bit, rest zero fill
  input  logic               s_tuser,   // [0] kind
  output logic               m_tvalid,
  input  logic               m_tready,
  output logic [TDATA_W-1:0] m_tdata,   // [0] result_bit, rest zero fill
  output logic               m_tlast,
  input  logic               psel,
  input  logic               penable,
  input  logic               pwrite,
  input  logic [ADDR_W-1:0]  paddr,
  input  logic [DATA_W-1:0]  pwdata,
  output logic [DATA_W-1:0]  prdata,
  output logic               pready
);

  localparam int TAPS  = 2 * RADIUS + 1;
  localparam int COL_W = $clog2(MAX_WIDTH);

  cfg_t             cfg;
  cell_ctl_t        cell_ctl;
  logic [COL_W-1:0] rd_addr;
  logic [COL_W-1:0] wr_addr;
  logic [TAPS:0]    chain;
  logic [TAPS-1:0]  row_all;
  logic [TAPS-1:0]  row_any;
  logic             hit;
  logic             m_result;

  bmdw_regs u_regs (
    .clk     (clk),
    .rst     (rst),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg     (cfg)
  );

  bmdw_ctrl #(
    .RADIUS    (RADIUS),
    .MAX_WIDTH (MAX_WIDTH)
  ) u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .cfg      (cfg),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_kind   (s_tuser),
    .s_bit    (s_tdata[0]),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_result (m_result),
    .m_last   (m_tlast),
    .hit      (hit),
    .cell_ctl (cell_ctl),
    .rd_addr  (rd_addr),
    .wr_addr  (wr_addr),
    .din0     (chain[0])
  );

  generate
    for (genvar k = 0; k < TAPS; k++) begin : g_cell
      bmdw_cell #(
        .RADIUS    (RADIUS),
        .MAX_WIDTH (MAX_WIDTH),
        .ROW       (k),
        .HAS_LINE  (k < TAPS - 1)
      ) u_cell (
        .clk      (clk),
        .ctl      (cell_ctl),
        .rd_addr  (rd_addr),
        .wr_addr  (wr_addr),
        .din      (chain[k]),
        .line_out (chain[k+1]),
        .row_all  (row_all[k]),
        .row_any  (row_any[k])
      );
    end
  endgenerate

  assign hit     = (cfg.operation == OP_DILATE) ? (|row_any) : (&row_all);
  assign m_tdata = {{(TDATA_W-1){1'b0}}, m_result};

endmodule

// ===== sv/bmdw_checker.sv =====
`timescale 1ns / 1ps
// Port-level checks for the binary morphology disk window, bound to the top level.
// Depends on bmdw_pkg and on the top-level port names.
module bmdw_checker import bmdw_pkg::*; (
  input logic               clk,
  input logic               rst,
  input logic               s_tvalid,
  input logic               s_tready,
  input logic               m_tvalid,
  input logic               m_tready,
  input logic [TDATA_W-1:0] m_tdata,
  input logic               m_tlast
);

  a_reset_empty: assert property (@(posedge clk) rst |=> !m_tvalid)
    else $error("Output valid right after reset.");

  a_stall_hold: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tlast))
    else $error("Stalled output transfer changed.");

  a_ready_when_empty: assert property (@(posedge clk) disable iff (rst)
    !m_tvalid |-> s_tready)
    else $error("Input stalled while the output register is empty.");

  a_last_is_border: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && m_tlast |-> m_tdata == TDATA_W'(0))
    else $error("Last pixel of a frame is a border pixel and must be zero.");

endmodule

bind binary_morphology_disk_window bmdw_checker u_bmdw_checker (.*);
